>>> hdl/trtf_pkg.sv
package trtf_pkg;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int CAP_W    = 5;
    localparam int MINF_W   = 4;

    // Wide enough to compare a fill against any supported depth
    localparam int DEPTH_CMP_W = 9;

    // Default storage shape
    localparam int DEPTH_DEF     = 16;
    localparam int DATA_BITS_DEF = 32;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_MIN_FILL = 1'b1;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd9;
    localparam logic [MINF_W-1:0] MINF_RESET = 4'd3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_A = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_B = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LOW   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_AGAIN = 2'd3;

    // Control outcome of one item, handed from the controller to the top level
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                removed;
        logic [FILL_W-1:0]   fill;
        logic                rd_ok;
    } t_trtf_result;

endpackage

>>> hdl/two_reader_threshold_fifo_unit.sv
// A result appears on o_valid in the cycle after start is taken.
// Throughput: one command per cycle; busy is always low and the receiver
// cannot stall, so results leave at the rate commands arrive.
// Reset (i_rst_n low at a clock edge): clears head, tail, fill and both read
// flags, sets capacity to 9 and min_fill to 3; stored elements are not cleared.
module two_reader_threshold_fifo_unit #(
    parameter int DEPTH     = trtf_pkg::DEPTH_DEF,
    parameter int DATA_BITS = trtf_pkg::DATA_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [trtf_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [trtf_pkg::VALUE_W-1:0] i_value,
    // result channel
    output logic                                o_valid,
    output logic [trtf_pkg::STATUS_W-1:0]       o_status,
    output logic signed [trtf_pkg::VALUE_W-1:0] o_data,
    output logic                                o_removed,
    output logic [trtf_pkg::FILL_W-1:0]         o_fill,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [trtf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [trtf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [trtf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import trtf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic [CAP_W-1:0]  r_capacity;
    logic [MINF_W-1:0] r_min_fill;

    logic             accept;
    logic             cfg_wr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic [DATA_BITS-1:0] wr_data;
    logic [DATA_BITS-1:0] rd_data;
    logic [VALUE_W-1:0]   rd_word;
    t_trtf_result         result;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_min_fill <= MINF_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_CAPACITY: r_capacity <= pwdata[CAP_W-1:0];
                REG_MIN_FILL: r_min_fill <= pwdata[MINF_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[2])
            REG_CAPACITY: prdata = APB_DATA_W'(r_capacity);
            REG_MIN_FILL: prdata = APB_DATA_W'(r_min_fill);
            default:      prdata = '0;
        endcase
    end

    // Fit the value to the storage width and back
    generate
        if (DATA_BITS >= VALUE_W) begin : g_wide
            assign wr_data = DATA_BITS'($unsigned(i_value));
            assign rd_word = rd_data[VALUE_W-1:0];
        end else begin : g_narrow
            assign wr_data = i_value[DATA_BITS-1:0];
            assign rd_word = VALUE_W'($signed(rd_data));
        end
    endgenerate

    trtf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cmd      (i_cmd),
        .i_capacity (r_capacity),
        .i_min_fill (r_min_fill),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_valid    (o_valid),
        .o_result   (result)
    );

    trtf_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Drive the result transfer
    assign o_status  = result.status;
    assign o_removed = result.removed;
    assign o_fill    = result.fill;
    assign o_data    = result.rd_ok ? $signed(rd_word) : '0;

`ifndef SYNTHESIS
    a_valid_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start))
        else $error("result without a taken command");

    a_removed_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_removed) |-> (o_status == ST_OK))
        else $error("head removed by a refused read");

    a_data_zero_on_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_data == '0 && !o_removed))
        else $error("refused command returned data");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (DEPTH_CMP_W'(o_fill) <= DEPTH_CMP_W'(DEPTH)))
        else $error("fill above storage depth");
`endif

endmodule

>>> hdl/trtf_ram.sv
module trtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/trtf_ctrl.sv
module trtf_ctrl #(
    parameter int DEPTH = trtf_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [trtf_pkg::CMD_W-1:0]   i_cmd,
    input  logic [trtf_pkg::CAP_W-1:0]   i_capacity,
    input  logic [trtf_pkg::MINF_W-1:0]  i_min_fill,
    output logic                         o_wr_en,
    output logic [$clog2(DEPTH)-1:0]     o_wr_addr,
    output logic                         o_rd_en,
    output logic [$clog2(DEPTH)-1:0]     o_rd_addr,
    output logic                         o_valid,
    output trtf_pkg::t_trtf_result       o_result
);

    import trtf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0]       PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [DEPTH_CMP_W-1:0] DEPTH_CMP = DEPTH_CMP_W'(DEPTH);

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_read_a, n_read_a;
    logic              r_read_b, n_read_b;
    logic              r_valid;
    t_trtf_result      r_result, n_result;

    logic full;
    logic low;
    logic is_a;
    logic mine;
    logic other;

    // Refusal conditions on the current state
    assign full  = (r_fill >= i_capacity) || (DEPTH_CMP_W'(r_fill) >= DEPTH_CMP);
    assign low   = (r_fill <= {1'b0, i_min_fill}) || (r_fill == '0);
    assign is_a  = (i_cmd == CMD_READ_A);
    assign mine  = is_a ? r_read_a : r_read_b;
    assign other = is_a ? r_read_b : r_read_a;

    // Decide the item's outcome and the next state
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_fill   = r_fill;
        n_read_a = r_read_a;
        n_read_b = r_read_b;
        n_result = '0;
        n_result.status = ST_OK;
        o_wr_en  = 1'b0;
        o_rd_en  = 1'b0;
        if (i_accept) begin
            case (i_cmd)
                CMD_WRITE: begin
                    if (full) begin
                        n_result.status = ST_FULL;
                    end else begin
                        o_wr_en = 1'b1;
                        n_tail  = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                        n_fill  = r_fill + 1'b1;
                    end
                end
                CMD_READ_A, CMD_READ_B: begin
                    if (mine) begin
                        n_result.status = ST_AGAIN;
                    end else if (low) begin
                        n_result.status = ST_LOW;
                    end else begin
                        o_rd_en        = 1'b1;
                        n_result.rd_ok = 1'b1;
                        if (other) begin
                            n_head   = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                            n_fill   = r_fill - 1'b1;
                            n_read_a = 1'b0;
                            n_read_b = 1'b0;
                            n_result.removed = 1'b1;
                        end else if (is_a) begin
                            n_read_a = 1'b1;
                        end else begin
                            n_read_b = 1'b1;
                        end
                    end
                end
                default: begin
                    // unused command: no change
                end
            endcase
        end
        n_result.fill = n_fill;
    end

    assign o_wr_addr = r_tail;
    assign o_rd_addr = r_head;

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_fill   <= '0;
            r_read_a <= 1'b0;
            r_read_b <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fill   <= n_fill;
            r_read_a <= n_read_a;
            r_read_b <= n_read_b;
            r_valid  <= i_accept;
        end
    end

    // Hold the result fields for the following cycle
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trtf_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 128;

    // Command code that the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] data;
        logic                      removed;
        logic [FILL_W-1:0]         fill;
    } t_fifo_outcome;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [CMD_W-1:0] i_cmd;
    logic signed [VALUE_W-1:0] i_value;
    logic o_valid;
    logic [STATUS_W-1:0] o_status;
    logic signed [VALUE_W-1:0] o_data;
    logic o_removed;
    logic [FILL_W-1:0] o_fill;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // Shadow copy of the buffer state and its registers
    logic [VALUE_W-1:0] shadow_entries [DEPTH];
    logic [3:0]         shadow_head;
    logic [3:0]         shadow_tail;
    logic [FILL_W-1:0]  shadow_fill;
    logic               shadow_read_a;
    logic               shadow_read_b;
    logic [CAP_W-1:0]   shadow_capacity;
    logic [MINF_W-1:0]  shadow_min_fill;

    t_fifo_outcome pending_outcomes [$];
    int fail_count;
    int stall_cycles;
    int burst_left;

    two_reader_threshold_fifo_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cmd     (i_cmd),
        .i_value   (i_value),
        .o_valid   (o_valid),
        .o_status  (o_status),
        .o_data    (o_data),
        .o_removed (o_removed),
        .o_fill    (o_fill),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one command to the shadow state and return the outcome it must produce
    function automatic t_fifo_outcome predict_fifo_op(logic [CMD_W-1:0] cmd,
                                                      logic [VALUE_W-1:0] value);
        t_fifo_outcome r;
        logic [FILL_W-1:0] cap_eff;
        logic is_a;
        logic mine;
        logic other;
        r.status  = ST_OK;
        r.data    = '0;
        r.removed = 1'b0;
        cap_eff = (shadow_capacity > DEPTH) ? FILL_W'(DEPTH) : shadow_capacity;
        case (cmd)
            CMD_WRITE: begin
                if (shadow_fill >= cap_eff) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_tail] = value;
                    shadow_tail = shadow_tail + 4'd1;
                    shadow_fill = shadow_fill + 5'd1;
                end
            end
            CMD_READ_A, CMD_READ_B: begin
                is_a  = (cmd == CMD_READ_A);
                mine  = is_a ? shadow_read_a : shadow_read_b;
                other = is_a ? shadow_read_b : shadow_read_a;
                // already-read refusal takes priority over the fill threshold
                if (mine) begin
                    r.status = ST_AGAIN;
                end else if (shadow_fill <= shadow_min_fill || shadow_fill == 0) begin
                    r.status = ST_LOW;
                end else begin
                    r.data = shadow_entries[shadow_head];
                    if (other) begin
                        shadow_head   = shadow_head + 4'd1;
                        shadow_fill   = shadow_fill - 5'd1;
                        shadow_read_a = 1'b0;
                        shadow_read_b = 1'b0;
                        r.removed     = 1'b1;
                    end else if (is_a) begin
                        shadow_read_a = 1'b1;
                    end else begin
                        shadow_read_b = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.fill = shadow_fill;
        return r;
    endfunction

    // Compare each result transfer with the oldest pending outcome
    always @(posedge i_clk) begin : check_results
        t_fifo_outcome want;
        if (i_rst_n && o_valid) begin
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with no command outstanding");
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_data !== want.data) begin
                    $error("data: expected %0d, got %0d", want.data, o_data);
                    fail_count++;
                end
                if (o_removed !== want.removed) begin
                    $error("removed: expected %0d, got %0d", want.removed, o_removed);
                    fail_count++;
                end
                if (o_fill !== want.fill) begin
                    $error("fill: expected %0d, got %0d", want.fill, o_fill);
                    fail_count++;
                end
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Drive one command and hold it until the block takes the transfer
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
        @(negedge i_clk);
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_outcomes = {pending_outcomes, predict_fifo_op(cmd, value)};
    endtask

    // Drop start for a number of cycles
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Read a register back and compare it with the shadow copy
    task automatic read_register(input logic idx);
        logic [APB_DATA_W-1:0] want;
        logic [APB_DATA_W-1:0] mask;
        want = (idx == REG_CAPACITY) ? APB_DATA_W'(shadow_capacity)
                                     : APB_DATA_W'(shadow_min_fill);
        mask = (idx == REG_CAPACITY) ? APB_DATA_W'({CAP_W{1'b1}})
                                     : APB_DATA_W'({MINF_W{1'b1}});
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if ((prdata & mask) !== want) begin
            $error("register %0d: expected %0d, got %0d", idx, want, prdata & mask);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register while the block is idle, then read it back
    task automatic set_register(input logic idx, input int unsigned value);
        drain();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == REG_CAPACITY) shadow_capacity = CAP_W'(value);
        else shadow_min_fill = MINF_W'(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_register(idx);
    endtask

    // Mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_register_reset;
        read_register(REG_CAPACITY);
        read_register(REG_MIN_FILL);
    endtask

    // Empty reads, the ignored code, extreme values and a full two-reader pass
    task automatic test_basic_transfers;
        send_item(CMD_READ_A, 32'h0);
        send_item(CMD_READ_B, 32'h0);
        send_item(CMD_UNUSED, 32'hDEAD_BEEF);
        send_item(CMD_WRITE, 32'h8000_0000);
        send_item(CMD_WRITE, 32'h7FFF_FFFF);
        send_item(CMD_WRITE, 32'hFFFF_FFFF);
        send_item(CMD_WRITE, 32'h0000_0000);
        send_item(CMD_READ_A, 32'h0);
        send_item(CMD_READ_A, 32'h0);
        send_item(CMD_READ_B, 32'h0);
    endtask

    // Fill to the reset capacity and push one more
    task automatic test_full_refusal;
        repeat (7) send_item(CMD_WRITE, $urandom);
    endtask

    // A reader that already took the head is refused before the fill check
    task automatic test_check_order;
        send_item(CMD_READ_A, 32'h0);
        set_register(REG_MIN_FILL, 15);
        send_item(CMD_READ_A, 32'h0);
        send_item(CMD_READ_B, 32'h0);
    endtask

    // Zero capacity, and capacity lowered below the current fill
    task automatic test_capacity_extremes;
        set_register(REG_CAPACITY, 0);
        send_item(CMD_WRITE, $urandom);
        set_register(REG_CAPACITY, 1);
        send_item(CMD_WRITE, $urandom);
    endtask

    // Phases of mixed traffic under varied register settings
    task automatic test_random_traffic;
        int unsigned cap;
        int unsigned minf;
        int unsigned write_pct;
        logic [CMD_W-1:0] cmd;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin cap = 31; minf = 0;  end
                1: begin cap = 16; minf = 15; end
                2: begin cap = 1;  minf = 0;  end
                3: begin cap = 12; minf = 15; end
                4: begin cap = 0;  minf = 0;  end
                5: begin cap = 16; minf = 0;  end
                default: begin
                    minf = $urandom_range(0, 6);
                    cap  = $urandom_range(minf + 1, 16);
                end
            endcase
            set_register(REG_CAPACITY, cap);
            set_register(REG_MIN_FILL, minf);
            write_pct = $urandom_range(25, 75);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) == 0) drain();
                if ($urandom_range(0, 99) < 2) cmd = CMD_UNUSED;
                else if ($urandom_range(0, 99) < write_pct) cmd = CMD_WRITE;
                else if ($urandom_range(0, 1) == 0) cmd = CMD_READ_A;
                else cmd = CMD_READ_B;
                hold_off(pick_gap());
                send_item(cmd, pick_value());
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = CMD_WRITE;
        i_value = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        fail_count   = 0;
        stall_cycles = 0;
        burst_left   = 0;
        shadow_head     = '0;
        shadow_tail     = '0;
        shadow_fill     = '0;
        shadow_read_a   = 1'b0;
        shadow_read_b   = 1'b0;
        shadow_capacity = CAP_RESET;
        shadow_min_fill = MINF_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_reset();
        test_basic_transfers();
        test_full_refusal();
        test_check_order();
        test_capacity_extremes();
        test_random_traffic();

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
